/* sv/sji_pkg.sv */
// ----------------------------------------------------------------------------
// sji_pkg: shared definitions for the sparse Jacobi solver
// Sizes, field widths, input modes, register indexes and saturation helpers.
// ----------------------------------------------------------------------------
package sji_pkg;

  localparam int MAX_DIM      = 1024;
  localparam int MAX_NZ       = 4096;
  localparam int DIM_AW       = $clog2(MAX_DIM);
  localparam int NZ_AW        = $clog2(MAX_NZ);
  localparam int CS_AW        = $clog2(MAX_DIM + 1);
  localparam int SIZE_W       = 11;
  localparam int SWEEP_W      = 16;
  localparam int MODE_W       = 3;
  localparam int SLOT_W       = 13;
  localparam int ROW_W        = 10;
  localparam int PTR_W        = 13;
  localparam int VAL_W        = 32;
  localparam int ACC_W        = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [SWEEP_W-1:0] DEFAULT_SWEEPS = SWEEP_W'(150);

  localparam logic [MODE_W-1:0] MODE_COLPTR = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ENTRY  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_VECTOR = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RUN    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_COUNT = 2'd1;

  localparam logic KIND_RUN_DONE = 1'b0;
  localparam logic KIND_READ     = 1'b1;

  // Saturating 64-bit signed add.
  function automatic logic signed [ACC_W-1:0] sat_add64(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add64 = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add64 = s[ACC_W-1:0];
    end
  endfunction

endpackage

/* sv/sji_if.sv */
// ----------------------------------------------------------------------------
// sji_if: channel interfaces of the sparse Jacobi solver
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface sji_in_if;
  logic                              valid;
  logic                              ready;
  logic [sji_pkg::MODE_W-1:0]        mode;
  logic [sji_pkg::SLOT_W-1:0]        slot;
  logic [sji_pkg::ROW_W-1:0]         row;
  logic [sji_pkg::PTR_W-1:0]         pointer;
  logic signed [sji_pkg::VAL_W-1:0]  value;
  logic signed [sji_pkg::VAL_W-1:0]  start_value;
  modport source (output valid, mode, slot, row, pointer, value, start_value, input ready);
  modport sink   (input valid, mode, slot, row, pointer, value, start_value, output ready);
endinterface

interface sji_out_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic signed [sji_pkg::VAL_W-1:0]  solution;
  logic                              divide_fault;
  modport source (output valid, kind, solution, divide_fault, input ready);
  modport sink   (input valid, kind, solution, divide_fault, output ready);
endinterface

interface sji_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sji_pkg::CFG_IDX_W-1:0]     index;
  logic [sji_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/sparse_jacobi_iteration.sv */
// ----------------------------------------------------------------------------
// sparse_jacobi_iteration: sparse Jacobi solver, signed Q16.16
// Loads a symmetric matrix in compressed column form, runs Jacobi sweeps
// over memories and returns solution elements on request.
// ----------------------------------------------------------------------------
// Usage: in_ch carries load, run and read beats; out_ch returns one beat for
// each run and each read; cfg_ch writes matrix_size and sweep_count at any
// time (cfg ready is always high) and should only be used while idle.
// Load beats (column pointer, entry, vector) are taken one per cycle while
// the sequencer is idle; a read or run waiting for the output register holds
// them off. A read first reads the vector memory, then places the element in
// the output register. A run executes all sweeps before its result beat.
// Per column the sequencer fetches the column bounds, then takes each nonzero
// entry through entry read, vector read, multiply and accumulate (a skipped
// row stops after the vector read), checks for the end of the column, and
// runs the update with 64 divider steps, one quotient bit a step. A zero
// diagonal skips the division and keeps the old element. The current and
// next vectors are two banks that swap after each sweep; after the last
// sweep, the solution is copied row by row into the other bank so that both
// banks agree on every row below matrix_size.
// Reset (rst_n low, synchronous) returns the sequencer to idle, restores
// matrix_size 1 and sweep_count 150, and clears the fault flag; memory
// contents are undefined until loaded. While the receiver stalls a result,
// the output register holds it; load beats are taken until a read or run waits.
// ----------------------------------------------------------------------------
module sparse_jacobi_iteration (
  input  logic     clk,
  input  logic     rst_n,
  sji_in_if.sink   in_ch,
  sji_out_if.source out_ch,
  sji_cfg_if.sink  cfg_ch
);

  localparam int DW = sji_pkg::VAL_W;
  localparam int AW = sji_pkg::ACC_W;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD   = 5'd1;
  localparam logic [4:0] S_C0   = 5'd2;
  localparam logic [4:0] S_C1   = 5'd3;
  localparam logic [4:0] S_C2   = 5'd4;
  localparam logic [4:0] S_E0   = 5'd5;
  localparam logic [4:0] S_E1   = 5'd6;
  localparam logic [4:0] S_E2   = 5'd7;
  localparam logic [4:0] S_E3   = 5'd8;
  localparam logic [4:0] S_F0   = 5'd9;
  localparam logic [4:0] S_F1   = 5'd10;
  localparam logic [4:0] S_F2   = 5'd11;
  localparam logic [4:0] S_DIV  = 5'd12;
  localparam logic [4:0] S_WB   = 5'd13;
  localparam logic [4:0] S_NXT  = 5'd14;
  localparam logic [4:0] S_ROUT = 5'd15;
  localparam logic [4:0] S_CP   = 5'd16;
  localparam logic [4:0] S_CW   = 5'd17;

  // Memories.
  logic [sji_pkg::PTR_W-1:0]          cs_mem   [sji_pkg::MAX_DIM+1];
  logic [sji_pkg::ROW_W+DW-1:0]       ent_mem  [sji_pkg::MAX_NZ];
  logic [DW-1:0]                      rhs_mem  [sji_pkg::MAX_DIM];
  logic [DW-1:0]                      vec0_mem [sji_pkg::MAX_DIM];
  logic [DW-1:0]                      vec1_mem [sji_pkg::MAX_DIM];

  logic [sji_pkg::PTR_W-1:0]          cs_q;
  logic [sji_pkg::ROW_W+DW-1:0]       ent_q;
  logic [DW-1:0]                      rhs_q, vec0_q, vec1_q;

  logic                               cs_re, ent_re, rhs_re, vec_re;
  logic [sji_pkg::CS_AW-1:0]          cs_ra;
  logic [sji_pkg::NZ_AW-1:0]          ent_ra;
  logic [sji_pkg::DIM_AW-1:0]         vec_ra;
  logic                               vec0_we, vec1_we;
  logic [sji_pkg::DIM_AW-1:0]         vec_wa;
  logic [DW-1:0]                      vec0_wd, vec1_wd;

  // Control and datapath registers.
  logic [4:0]                         state_r, state_nxt;
  logic [sji_pkg::SIZE_W-1:0]         size_r;
  logic [sji_pkg::SWEEP_W-1:0]        sweeps_r;
  logic [sji_pkg::SIZE_W-1:0]         n_r;
  logic [sji_pkg::SIZE_W-1:0]         i_r;
  logic [sji_pkg::SWEEP_W-1:0]        sw_r;
  logic                               bank_r;
  logic                               fault_r;
  logic                               oob_r;
  logic [sji_pkg::PTR_W-1:0]          lo_r, hi_r, p_r;
  logic signed [AW-1:0]               acc_r, prod_r, num_r;
  logic signed [DW-1:0]               val_r, diag_r, cur_i_r;
  logic                               have_diag_r;
  logic [sji_pkg::ROW_W-1:0]          row_r;
  logic [AW-1:0]                      dv_r;
  logic [DW-1:0]                      dsr_r, rem_r;
  logic                               neg_r;
  logic [5:0]                         cnt_r;

  logic                               out_valid_r, out_kind_r, out_fault_r;
  logic signed [DW-1:0]               out_sol_r;

  logic                               in_fire, out_free;
  logic signed [DW-1:0]               cur_q;
  logic [sji_pkg::ROW_W-1:0]          e_row;
  logic signed [DW-1:0]               e_val;
  logic [sji_pkg::SIZE_W-1:0]         n_clamp;

  // Update element: clamp quotient, apply sign, add x[i], saturate.
  logic [33:0]         q_clamp;
  logic signed [35:0]  q_signed, res_wide;
  logic signed [DW-1:0] res_sat;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.solution     = out_sol_r;
  assign out_ch.divide_fault = out_fault_r;

  assign cur_q = bank_r ? $signed(vec1_q) : $signed(vec0_q);
  assign e_row = ent_q[sji_pkg::ROW_W+DW-1:DW];
  assign e_val = $signed(ent_q[DW-1:0]);

  always_comb begin
    if (size_r == '0) begin
      n_clamp = sji_pkg::SIZE_W'(1);
    end else if (size_r > sji_pkg::SIZE_W'(sji_pkg::MAX_DIM)) begin
      n_clamp = sji_pkg::SIZE_W'(sji_pkg::MAX_DIM);
    end else begin
      n_clamp = size_r;
    end
  end

  // Memory port control.
  always_comb begin
    cs_re   = 1'b0;
    ent_re  = 1'b0;
    rhs_re  = 1'b0;
    vec_re  = 1'b0;
    cs_ra   = i_r[sji_pkg::CS_AW-1:0];
    ent_ra  = p_r[sji_pkg::NZ_AW-1:0];
    vec_ra  = i_r[sji_pkg::DIM_AW-1:0];
    vec0_we = 1'b0;
    vec1_we = 1'b0;
    vec_wa  = i_r[sji_pkg::DIM_AW-1:0];
    vec0_wd = in_ch.start_value;
    vec1_wd = in_ch.start_value;
    unique case (state_r)
      S_IDLE: begin
        vec_ra = in_ch.slot[sji_pkg::DIM_AW-1:0];
        vec_wa = in_ch.slot[sji_pkg::DIM_AW-1:0];
        if (in_fire && in_ch.mode == sji_pkg::MODE_READ) begin
          vec_re = 1'b1;
        end
        if (in_fire && in_ch.mode == sji_pkg::MODE_VECTOR &&
            in_ch.slot < sji_pkg::SLOT_W'(sji_pkg::MAX_DIM)) begin
          vec0_we = 1'b1;
          vec1_we = 1'b1;
        end
      end
      S_C0: cs_re = 1'b1;
      S_C1: begin
        cs_re = 1'b1;
        cs_ra = sji_pkg::CS_AW'(i_r + sji_pkg::SIZE_W'(1));
      end
      S_E0: ent_re = (p_r < hi_r);
      S_E1: begin
        vec_re = 1'b1;
        vec_ra = e_row;
      end
      S_F0: begin
        vec_re = 1'b1;
        rhs_re = 1'b1;
      end
      S_F1: begin
        // Zero or missing diagonal keeps the old element.
        vec0_wd = cur_q;
        vec1_wd = cur_q;
        if (diag_r == '0) begin
          vec0_we = bank_r;
          vec1_we = !bank_r;
        end
      end
      S_WB: begin
        vec0_wd = res_sat;
        vec1_wd = res_sat;
        vec0_we = bank_r;
        vec1_we = !bank_r;
      end
      S_CP: vec_re = 1'b1;
      S_CW: begin
        // Bring the idle bank in line with the solution.
        vec0_wd = cur_q;
        vec1_wd = cur_q;
        vec0_we = bank_r;
        vec1_we = !bank_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    q_clamp  = (dv_r > AW'(64'h2_0000_0000)) ? 34'h2_0000_0000 : dv_r[33:0];
    q_signed = neg_r ? -$signed({2'b00, q_clamp}) : $signed({2'b00, q_clamp});
    res_wide = q_signed + 36'(cur_i_r);
    if (res_wide > 36'sh0_7FFF_FFFF) begin
      res_sat = 32'sh7FFF_FFFF;
    end else if (res_wide < -36'sh0_8000_0000) begin
      res_sat = 32'sh8000_0000;
    end else begin
      res_sat = res_wide[DW-1:0];
    end
  end

  // Numerator b * 2^32 - acc, with the most negative acc treated as -MAX.
  logic signed [AW:0]    num_add;
  logic signed [AW+1:0]  num_sum;
  logic signed [AW-1:0]  num_sat;
  always_comb begin
    if (acc_r == {1'b1, {(AW-1){1'b0}}}) begin
      num_add = {2'b00, {(AW-1){1'b1}}};
    end else begin
      num_add = -{acc_r[AW-1], acc_r};
    end
    num_sum = (AW+2)'($signed({rhs_q, 32'b0})) + (AW+2)'(num_add);
    if (num_sum > (AW+2)'($signed({1'b0, {(AW-1){1'b1}}}))) begin
      num_sat = {1'b0, {(AW-1){1'b1}}};
    end else if (num_sum < (AW+2)'($signed({1'b1, {(AW-1){1'b0}}}))) begin
      num_sat = {1'b1, {(AW-1){1'b0}}};
    end else begin
      num_sat = num_sum[AW-1:0];
    end
  end

  // One restoring division step.
  logic [DW:0] div_t;
  assign div_t = {rem_r, dv_r[AW-1]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_ch.mode == sji_pkg::MODE_READ) begin
          state_nxt = S_RD;
        end else if (in_fire && in_ch.mode == sji_pkg::MODE_RUN) begin
          state_nxt = (sweeps_r == '0) ? S_ROUT : S_C0;
        end
      end
      S_RD:   if (out_free) state_nxt = S_IDLE;
      S_C0:   state_nxt = S_C1;
      S_C1:   state_nxt = S_C2;
      S_C2:   state_nxt = S_E0;
      S_E0:   state_nxt = (p_r < hi_r) ? S_E1 : S_F0;
      S_E1:   state_nxt = ({1'b0, e_row} >= n_r) ? S_E0 : S_E2;
      S_E2:   state_nxt = S_E3;
      S_E3:   state_nxt = S_E0;
      S_F0:   state_nxt = S_F1;
      S_F1:   state_nxt = (diag_r == '0) ? S_NXT : S_F2;
      S_F2:   state_nxt = S_DIV;
      S_DIV:  if (cnt_r == 6'd63) state_nxt = S_WB;
      S_WB:   state_nxt = S_NXT;
      S_NXT: begin
        if (i_r + sji_pkg::SIZE_W'(1) == n_r &&
            sw_r + sji_pkg::SWEEP_W'(1) == sweeps_r) begin
          state_nxt = S_CP;
        end else begin
          state_nxt = S_C0;
        end
      end
      S_CP:   state_nxt = S_CW;
      S_CW:   state_nxt = (i_r + sji_pkg::SIZE_W'(1) == n_r) ? S_ROUT : S_CP;
      S_ROUT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.mode == sji_pkg::MODE_COLPTR &&
        in_ch.slot <= sji_pkg::SLOT_W'(sji_pkg::MAX_DIM)) begin
      cs_mem[in_ch.slot[sji_pkg::CS_AW-1:0]] <= in_ch.pointer;
    end
    if (in_fire && in_ch.mode == sji_pkg::MODE_ENTRY &&
        in_ch.slot < sji_pkg::SLOT_W'(sji_pkg::MAX_NZ)) begin
      ent_mem[in_ch.slot[sji_pkg::NZ_AW-1:0]] <= {in_ch.row, in_ch.value};
    end
    if (in_fire && in_ch.mode == sji_pkg::MODE_VECTOR &&
        in_ch.slot < sji_pkg::SLOT_W'(sji_pkg::MAX_DIM)) begin
      rhs_mem[in_ch.slot[sji_pkg::DIM_AW-1:0]] <= in_ch.value;
    end
    if (vec0_we) vec0_mem[vec_wa] <= vec0_wd;
    if (vec1_we) vec1_mem[vec_wa] <= vec1_wd;
    if (cs_re)  cs_q  <= cs_mem[cs_ra];
    if (ent_re) ent_q <= ent_mem[ent_ra];
    if (rhs_re) rhs_q <= rhs_mem[i_r[sji_pkg::DIM_AW-1:0]];
    if (vec_re) begin
      vec0_q <= vec0_mem[vec_ra];
      vec1_q <= vec1_mem[vec_ra];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= sji_pkg::SIZE_W'(1);
      sweeps_r    <= sji_pkg::DEFAULT_SWEEPS;
      fault_r     <= 1'b0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == sji_pkg::REG_MATRIX_SIZE) begin
          size_r <= cfg_ch.data[sji_pkg::SIZE_W-1:0];
        end else if (cfg_ch.index == sji_pkg::REG_SWEEP_COUNT) begin
          sweeps_r <= cfg_ch.data;
        end
      end
      if (state_r == S_IDLE && in_fire && in_ch.mode == sji_pkg::MODE_RUN) begin
        fault_r <= 1'b0;
      end
      if (state_r == S_F1 && diag_r == '0) begin
        fault_r <= 1'b1;
      end
      if (state_r == S_NXT && i_r + sji_pkg::SIZE_W'(1) == n_r) begin
        bank_r <= !bank_r;
      end
      if ((state_r == S_RD || state_r == S_ROUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        oob_r <= (in_ch.slot >= sji_pkg::SLOT_W'(sji_pkg::MAX_DIM));
        n_r   <= n_clamp;
        i_r   <= '0;
        sw_r  <= '0;
      end
      S_C1: lo_r <= cs_q;
      S_C2: begin
        hi_r <= (cs_q > sji_pkg::PTR_W'(sji_pkg::MAX_NZ)) ?
                sji_pkg::PTR_W'(sji_pkg::MAX_NZ) : cs_q;
        p_r         <= lo_r;
        acc_r       <= '0;
        diag_r      <= '0;
        have_diag_r <= 1'b0;
      end
      S_E1: begin
        val_r <= e_val;
        row_r <= e_row;
        if ({1'b0, e_row} >= n_r) p_r <= p_r + sji_pkg::PTR_W'(1);
      end
      S_E2: prod_r <= val_r * cur_q;
      S_E3: begin
        acc_r <= sji_pkg::sat_add64(acc_r, prod_r);
        if ({1'b0, row_r} == i_r && !have_diag_r) begin
          have_diag_r <= 1'b1;
          diag_r      <= val_r;
        end
        p_r <= p_r + sji_pkg::PTR_W'(1);
      end
      S_F1: begin
        cur_i_r <= cur_q;
        num_r   <= num_sat;
      end
      S_F2: begin
        dv_r  <= num_r[AW-1] ? AW'(0) - AW'(num_r) : AW'(num_r);
        dsr_r <= diag_r[DW-1] ? DW'(0) - DW'(diag_r) : DW'(diag_r);
        neg_r <= num_r[AW-1] ^ diag_r[DW-1];
        rem_r <= '0;
        cnt_r <= '0;
      end
      S_DIV: begin
        if (div_t >= {1'b0, dsr_r}) begin
          rem_r <= DW'(div_t - {1'b0, dsr_r});
          dv_r  <= {dv_r[AW-2:0], 1'b1};
        end else begin
          rem_r <= div_t[DW-1:0];
          dv_r  <= {dv_r[AW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
      end
      S_NXT: begin
        if (i_r + sji_pkg::SIZE_W'(1) == n_r) begin
          i_r  <= '0;
          sw_r <= sw_r + sji_pkg::SWEEP_W'(1);
        end else begin
          i_r <= i_r + sji_pkg::SIZE_W'(1);
        end
      end
      S_CW: i_r <= i_r + sji_pkg::SIZE_W'(1);
      default: ;
    endcase
    if (state_r == S_RD && out_free) begin
      out_kind_r  <= sji_pkg::KIND_READ;
      out_sol_r   <= oob_r ? '0 : cur_q;
      out_fault_r <= fault_r;
    end else if (state_r == S_ROUT && out_free) begin
      out_kind_r  <= sji_pkg::KIND_RUN_DONE;
      out_sol_r   <= '0;
      out_fault_r <= fault_r;
    end
  end

endmodule

/* sv/sji_checker.sv */
// ----------------------------------------------------------------------------
// sji_checker: port-level checks for the sparse Jacobi solver
// Watches the handshakes and result beats of the top level and is bound to it.
// ----------------------------------------------------------------------------
module sji_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [sji_pkg::MODE_W-1:0]   in_mode,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_kind,
  input logic [sji_pkg::VAL_W-1:0]    out_solution
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_kind_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind))
    else $error("result kind changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == sji_pkg::MODE_READ |=> !in_ready)
    else $error("input taken while a read is in flight");

  a_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == sji_pkg::KIND_RUN_DONE |-> out_solution == '0)
    else $error("run finished beat carries a nonzero solution");

endmodule

bind sparse_jacobi_iteration sji_checker u_sji_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_mode      (in_ch.mode),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_kind     (out_ch.kind),
  .out_solution (out_ch.solution)
);

/* tb/sparse_jacobi_iteration_tb.sv */
// ----------------------------------------------------------------------------
// sparse_jacobi_iteration_tb: self-checking regression for the Jacobi solver
// Drives load, run and read beats with random gaps, stalls the result side,
// predicts every result in Q16.16 and compares each returned beat in order.
// ----------------------------------------------------------------------------
module sparse_jacobi_iteration_tb;
  import sji_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = MODE_READ + 3'd1;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
  localparam longint ACC_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;
  localparam longint Q32_MAX = 64'sh0000_0000_7fff_ffff;
  localparam longint Q32_MIN = -64'sh0000_0000_8000_0000;
  localparam logic [63:0] QUOT_LIMIT = 64'h2_0000_0000;
  localparam int IDLE_CYCLES = 8;
  localparam int STALL_CYCLES = 400;
  localparam int PRE_DIM = 32;
  localparam int PRE_NZ = 8;

  typedef struct {
    logic [MODE_W-1:0]        mode;
    logic [SLOT_W-1:0]        slot;
    logic [ROW_W-1:0]         row;
    logic [PTR_W-1:0]         pointer;
    logic signed [VAL_W-1:0]  value;
    logic signed [VAL_W-1:0]  start_value;
  } beat_t;

  typedef struct {
    logic                     kind;
    logic signed [VAL_W-1:0]  solution;
    logic                     divide_fault;
  } result_t;

  logic clk;
  logic rst_n;

  sji_in_if  in_ch();
  sji_out_if out_ch();
  sji_cfg_if cfg_ch();

  sparse_jacobi_iteration u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // Shadow state of the solver.
  logic [PTR_W-1:0]         col_start [MAX_DIM+1];
  logic [ROW_W-1:0]         ent_row   [MAX_NZ];
  logic signed [VAL_W-1:0]  ent_val   [MAX_NZ];
  logic signed [VAL_W-1:0]  rhs       [MAX_DIM];
  logic signed [VAL_W-1:0]  cur_x     [MAX_DIM];
  logic signed [VAL_W-1:0]  nxt_x     [MAX_DIM];
  bit                       fault;
  bit                       x_known   [MAX_DIM];
  logic [SIZE_W-1:0]        size_reg;
  logic [SWEEP_W-1:0]       sweep_reg;

  result_t pending_results [$];
  int errors;
  int beats_sent;
  int runs_sent;
  int reads_sent;
  int results_seen;
  int burst_left;
  bit no_gaps;
  int hold_id;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("sparse_jacobi_iteration regression: fail");
    $finish;
  end

  function automatic longint add_sat(longint a, longint b);
    longint s;
    s = a + b;
    if (a >= 0 && b >= 0 && s < 0) return ACC_MAX;
    if (a < 0 && b < 0 && s >= 0) return ACC_MIN;
    return s;
  endfunction

  function automatic int size_used();
    int n;
    n = size_reg;
    if (n < 1) n = 1;
    if (n > MAX_DIM) n = MAX_DIM;
    return n;
  endfunction

  function automatic void jacobi_sweep(int n);
    int unsigned lo, hi, p, r;
    longint acc, diag, num, res;
    logic [63:0] mn, md, q;
    bit have_diag;
    for (int i = 0; i < n; i++) begin
      lo = col_start[i];
      hi = col_start[i+1];
      if (hi > MAX_NZ) hi = MAX_NZ;
      acc = 0;
      diag = 0;
      have_diag = 0;
      for (p = lo; p < hi; p++) begin
        r = ent_row[p];
        if (r < n) begin
          acc = add_sat(acc, longint'(ent_val[p]) * longint'(cur_x[r]));
          if (r == i && !have_diag) begin
            have_diag = 1;
            diag = ent_val[p];
          end
        end
      end
      if (diag == 0) begin
        fault = 1;
        nxt_x[i] = cur_x[i];
      end else begin
        if (acc == ACC_MIN) num = add_sat(longint'(rhs[i]) <<< 32, ACC_MAX);
        else num = add_sat(longint'(rhs[i]) <<< 32, -acc);
        mn = (num < 0) ? 64'(-num) : 64'(num);
        md = (diag < 0) ? 64'(-diag) : 64'(diag);
        q = mn / md;
        if (q > QUOT_LIMIT) q = QUOT_LIMIT;
        res = ((num < 0) != (diag < 0)) ? -longint'(q) : longint'(q);
        res = res + longint'(cur_x[i]);
        if (res > Q32_MAX) res = Q32_MAX;
        if (res < Q32_MIN) res = Q32_MIN;
        nxt_x[i] = res[31:0];
      end
    end
    for (int i = 0; i < n; i++) cur_x[i] = nxt_x[i];
  endfunction

  // Updates the shadow state for one accepted beat and queues its result.
  function automatic void jacobi_predict(beat_t b);
    result_t res;
    int n;
    case (b.mode)
      MODE_COLPTR: if (b.slot <= MAX_DIM) col_start[b.slot] = b.pointer;
      MODE_ENTRY: begin
        if (b.slot < MAX_NZ) begin
          ent_row[b.slot] = b.row;
          ent_val[b.slot] = b.value;
        end
      end
      MODE_VECTOR: begin
        if (b.slot < MAX_DIM) begin
          rhs[b.slot] = b.value;
          cur_x[b.slot] = b.start_value;
          x_known[b.slot] = 1;
        end
      end
      MODE_RUN: begin
        n = size_used();
        fault = 0;
        for (int s = 0; s < sweep_reg; s++) jacobi_sweep(n);
        res.kind = KIND_RUN_DONE;
        res.solution = '0;
        res.divide_fault = fault;
        pending_results.push_back(res);
      end
      MODE_READ: begin
        res.kind = KIND_READ;
        res.solution = (b.slot < MAX_DIM) ? cur_x[b.slot] : '0;
        res.divide_fault = fault;
        pending_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(beat_t b);
    int gap;
    if (burst_left == 0) begin
      if (!no_gaps) begin
        gap = $urandom_range(1, 6);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= b.mode;
    in_ch.slot        <= b.slot;
    in_ch.row         <= b.row;
    in_ch.pointer     <= b.pointer;
    in_ch.value       <= b.value;
    in_ch.start_value <= b.start_value;
    do @(posedge clk); while (!in_ch.ready);
    jacobi_predict(b);
    if (b.mode <= MODE_READ) beats_sent++;
    if (b.mode == MODE_RUN) runs_sent++;
    if (b.mode == MODE_READ) reads_sent++;
  endtask

  task automatic send_fields(logic [MODE_W-1:0] mode, int slot, int row, int ptr,
                             logic [31:0] val, logic [31:0] start);
    beat_t b;
    b.mode = mode;
    b.slot = SLOT_W'(slot);
    b.row = ROW_W'(row);
    b.pointer = PTR_W'(ptr);
    b.value = val;
    b.start_value = start;
    send_beat(b);
  endtask

  // Waits until every expected result is back and the block has settled.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_MATRIX_SIZE) size_reg = data[SIZE_W-1:0];
    else if (idx == REG_SWEEP_COUNT) sweep_reg = data;
  endtask

  function automatic logic [31:0] small_q(int mag);
    return $urandom_range(0, 19) == 0 ? $urandom : 32'($signed($urandom_range(0, 2*mag)) - mag);
  endfunction

  function automatic int known_slot();
    int s;
    for (int k = 0; k < 16; k++) begin
      s = $urandom_range(0, 2 * PRE_DIM - 1);
      if (x_known[s]) return s;
    end
    return MAX_DIM + $urandom_range(0, 100);
  endfunction

  // Fills the low columns and vector rows and the top of the entry store, so
  // that no later access meets an unwritten entry.
  task automatic test_preload();
    no_gaps = 1;
    for (int c = 0; c <= PRE_DIM; c++) send_fields(MODE_COLPTR, c, 0, 0, 0, 0);
    for (int e = MAX_NZ - PRE_NZ; e < MAX_NZ; e++) send_fields(MODE_ENTRY, e, 0, 0, 0, 0);
    for (int v = 0; v < PRE_DIM; v++) send_fields(MODE_VECTOR, v, 0, 0, 0, 0);
    no_gaps = 0;
    settle();
  endtask

  task automatic test_directed();
    write_reg(REG_MATRIX_SIZE, 2);
    write_reg(REG_SWEEP_COUNT, 1);
    // Column 0 is well formed, column 1 has a zero diagonal and a skipped row.
    send_fields(MODE_COLPTR, 0, 0, 0, 0, 0);
    send_fields(MODE_COLPTR, 1, 0, 2, 0, 0);
    send_fields(MODE_COLPTR, 2, 0, 5, 0, 0);
    send_fields(MODE_ENTRY, 0, 0, 0, 32'h0002_0000, 0);
    send_fields(MODE_ENTRY, 1, 1, 0, 32'h0001_0000, 0);
    send_fields(MODE_ENTRY, 2, 1023, 0, 32'h7fff_ffff, 0);
    send_fields(MODE_ENTRY, 3, 1, 0, 32'h0, 0);
    send_fields(MODE_ENTRY, 4, 1, 0, 32'h8000_0000, 0);
    send_fields(MODE_VECTOR, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000);
    send_fields(MODE_VECTOR, 1, 0, 0, 32'h8000_0000, 32'h7fff_ffff);
    // Loads beyond each store are dropped.
    send_fields(MODE_COLPTR, 8191, 0, 8191, 0, 0);
    send_fields(MODE_ENTRY, MAX_NZ, 1023, 0, 32'hffff_ffff, 0);
    send_fields(MODE_VECTOR, MAX_DIM, 0, 0, 32'hffff_ffff, 32'hffff_ffff);
    send_fields(MODE_SPARE_LAST, 8191, 1023, 8191, 32'hffff_ffff, 32'hffff_ffff);
    send_fields(MODE_RUN, 0, 0, 0, 0, 0);
    send_fields(MODE_READ, 0, 0, 0, 0, 0);
    send_fields(MODE_READ, 1, 0, 0, 0, 0);
    send_fields(MODE_READ, 8191, 0, 0, 0, 0);
    settle();
    // Column end past the entry store is clamped; start past end is empty.
    write_reg(REG_MATRIX_SIZE, 3);
    send_fields(MODE_COLPTR, 0, 0, MAX_NZ - 6, 0, 0);
    send_fields(MODE_COLPTR, 1, 0, MAX_NZ - 4, 0, 0);
    send_fields(MODE_COLPTR, 2, 0, 8191, 0, 0);
    send_fields(MODE_COLPTR, 3, 0, 0, 0, 0);
    send_fields(MODE_ENTRY, MAX_NZ - 6, 0, 0, 32'h0001_0000, 0);
    send_fields(MODE_ENTRY, MAX_NZ - 3, 1, 0, 32'hffff_0000, 0);
    send_fields(MODE_RUN, 0, 0, 0, 0, 0);
    send_fields(MODE_READ, 2, 0, 0, 0, 0);
    settle();
    // A wider matrix with a single sweep, then oversize and zero settings.
    write_reg(REG_MATRIX_SIZE, PRE_DIM);
    send_fields(MODE_RUN, 0, 0, 0, 0, 0);
    send_fields(MODE_READ, PRE_DIM - 1, 0, 0, 0, 0);
    settle();
    write_reg(REG_MATRIX_SIZE, 16'hffff);
    write_reg(REG_SWEEP_COUNT, 0);
    send_fields(MODE_RUN, 0, 0, 0, 0, 0);
    settle();
    write_reg(REG_MATRIX_SIZE, 0);
    write_reg(REG_SWEEP_COUNT, 16'hffff);
    send_fields(MODE_READ, 3, 0, 0, 0, 0);
    settle();
  endtask

  // The receiver holds off while reads keep coming, so the input must stall.
  task automatic test_backpressure();
    hold_id++;
    for (int k = 0; k < 40; k++) send_fields(MODE_READ, known_slot(), 0, 0, 0, 0);
    settle();
  endtask

  task automatic run_problem();
    int n, base, ptr, cnt [33];
    logic [31:0] v;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
    settle();
    write_reg(REG_MATRIX_SIZE, (n == 1 && $urandom_range(0, 1)) ? 0 : n);
    write_reg(REG_SWEEP_COUNT, $urandom_range(0, 6));
    base = $urandom_range(0, MAX_NZ - 4 * 33);
    ptr = base;
    for (int c = 0; c < n; c++) cnt[c] = $urandom_range(0, 3);
    for (int c = 0; c <= n; c++) begin
      send_fields(MODE_COLPTR, c, 0, ptr, 0, 0);
      if (c < n) ptr += cnt[c];
    end
    ptr = base;
    for (int c = 0; c < n; c++) begin
      for (int k = 0; k < cnt[c]; k++) begin
        if (k == 0 && $urandom_range(0, 9) != 0) begin
          v = {$urandom_range(1, 8), 16'h0} ^ {32{$urandom_range(0, 1) == 1}};
          if ($urandom_range(0, 19) == 0) v = $urandom_range(0, 3) == 0 ? 0 : $urandom;
          send_fields(MODE_ENTRY, ptr, c, 0, v, $urandom);
        end else begin
          send_fields(MODE_ENTRY, ptr,
                      $urandom_range(0, 6) == 0 ? $urandom_range(0, 1023)
                                                : $urandom_range(0, n - 1),
                      $urandom, small_q(32'h8000), $urandom);
        end
        ptr++;
      end
    end
    // Now and then the previous solution is kept as a warm start.
    for (int i = 0; i < n; i++) begin
      if (!x_known[i] || $urandom_range(0, 6) != 0)
        send_fields(MODE_VECTOR, i, $urandom, $urandom, small_q(32'h4_0000),
                    small_q(32'h4_0000));
    end
    send_fields(MODE_RUN, $urandom, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < n; i++) send_fields(MODE_READ, i, $urandom, $urandom, $urandom, 0);
    if ($urandom_range(0, 3) == 0)
      send_fields(MODE_READ, $urandom_range(MAX_DIM, 8191), 0, 0, 0, 0);
  endtask

  task automatic send_noise();
    beat_t b;
    b.mode = MODE_W'($urandom_range(0, 7));
    b.slot = SLOT_W'($urandom);
    b.row = ROW_W'($urandom);
    b.pointer = PTR_W'($urandom);
    b.value = $urandom;
    b.start_value = $urandom;
    if (b.mode == MODE_RUN)
      b.mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    if (b.mode == MODE_READ) b.slot = SLOT_W'(known_slot());
    send_beat(b);
  endtask

  task automatic test_random();
    while (beats_sent < 1800) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) send_noise();
      end else begin
        run_problem();
      end
    end
    settle();
  endtask

  // Receiver: ready follows a randomly redrawn pattern, with a long hold-off
  // whenever one is requested.
  int hold_seen;
  int hold_left;
  int pat_cnt;
  int pat_mode;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
      pat_cnt <= 0;
      pat_mode <= 0;
    end else if (hold_seen != hold_id) begin
      hold_seen <= hold_id;
      hold_left <= STALL_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      pat_cnt <= pat_cnt + 1;
      if (pat_cnt % 64 == 63) pat_mode <= $urandom_range(0, 2);
      case (pat_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: kind %0d solution %h",
               out_ch.kind, out_ch.solution);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d actual %0d", want.kind, out_ch.kind);
          errors++;
        end
        if (out_ch.solution !== want.solution) begin
          $error("solution: expected %h actual %h", want.solution, out_ch.solution);
          errors++;
        end
        if (out_ch.divide_fault !== want.divide_fault) begin
          $error("divide_fault: expected %0d actual %0d", want.divide_fault,
                 out_ch.divide_fault);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.slot = '0;
    in_ch.row = '0;
    in_ch.pointer = '0;
    in_ch.value = '0;
    in_ch.start_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    errors = 0;
    beats_sent = 0;
    runs_sent = 0;
    reads_sent = 0;
    results_seen = 0;
    burst_left = 0;
    no_gaps = 0;
    hold_id = 0;
    size_reg = 1;
    sweep_reg = DEFAULT_SWEEPS;
    fault = 0;
    for (int i = 0; i < MAX_DIM; i++) x_known[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_preload();
    test_directed();
    test_backpressure();
    test_random();
    repeat (200) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end
    $display("Covered %0d accepted beats, %0d runs and %0d reads; %0d results checked.",
             beats_sent, runs_sent, reads_sent, results_seen);
    $display("Runs up to size %0d, oversize, zero size and zero sweeps; %0d mismatches.",
             PRE_DIM, errors);
    if (errors == 0) begin
      $display("sparse_jacobi_iteration regression: pass");
    end else begin
      $display("sparse_jacobi_iteration regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sji_pkg.sv
sv/sji_if.sv
sv/sparse_jacobi_iteration.sv
sv/sji_checker.sv
tb/sparse_jacobi_iteration_tb.sv
